/* sv/tff_pkg.sv */
// shared constants and types for the thermocouple fault filter
`timescale 1ns / 1ps

package tff_pkg;

  localparam int TEMP_W   = 12;
  localparam int FILT_W   = 20;
  localparam int FRAC_W   = 8;
  localparam int CNT_W    = 5;
  localparam int STATUS_W = 2;

  // 4*old + (sample << 8) stays below 5 * 2^20
  localparam int SUM_W      = 23;
  localparam int DIV5_SHIFT = 25;
  localparam logic [SUM_W-1:0] DIV5_MUL = 23'd6710887;  // ceil(2^25 / 5)

  localparam logic [STATUS_W-1:0] ST_UPDATED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_IGNORED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FAILURE = 2'd2;

  localparam logic REG_MAX_ERRORS    = 1'b0;
  localparam logic REG_MAX_SAFE_TEMP = 1'b1;

  localparam logic [CNT_W-1:0]  MAX_ERRORS_RST    = 5'd5;
  localparam logic [TEMP_W-1:0] MAX_SAFE_TEMP_RST = 12'd640;
  localparam logic [CNT_W-1:0]  CNT_SAT           = 5'd31;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [FILT_W-1:0]   filtered_temp;
    logic                error_state;
    logic [CNT_W-1:0]    error_count;
  } result_t;

endpackage

/* sv/tff_cell.sv */
// one stage of the error-bit window: holds a bit and passes it on each update
`timescale 1ns / 1ps

module tff_cell (
  input  logic clk,
  input  logic shift,
  input  logic bit_in,
  output logic bit_out
);

  logic err_bit;

  always_ff @(posedge clk) begin
    if (shift) begin
      err_bit <= bit_in;
    end
  end

  assign bit_out = err_bit;

endmodule

/* sv/tff_ema.sv */
// filter update: (4*old + (sample << 8)) / 5 by reciprocal multiply
`timescale 1ns / 1ps

module tff_ema (
  input  logic [tff_pkg::FILT_W-1:0] old_temp,
  input  logic [tff_pkg::TEMP_W-1:0] sample,
  output logic [tff_pkg::FILT_W-1:0] new_temp
);

  logic [tff_pkg::SUM_W-1:0]   sum;
  logic [2*tff_pkg::SUM_W-1:0] prod;

  always_comb begin
    sum  = {1'b0, old_temp, 2'b00}
         + {3'b000, sample, {tff_pkg::FRAC_W{1'b0}}};
    prod = {{tff_pkg::SUM_W{1'b0}}, sum} * {{tff_pkg::SUM_W{1'b0}}, tff_pkg::DIV5_MUL};
    new_temp = prod[tff_pkg::DIV5_SHIFT +: tff_pkg::FILT_W];
  end

endmodule

/* sv/thermocouple_fault_filter_unit.sv */
// thermocouple fault filter: error window chain, filter update, output register
// latency: a result is valid the cycle after its input beat is accepted
// throughput: one beat per cycle unless stalled, set by the filter update loop
//   (one add and one reciprocal multiply per cycle back into filter register)
// reset: filter value, window counters and output valid clear, registers go to
//   defaults; window cells are not cleared, the fill count keeps them unread
`timescale 1ns / 1ps

module thermocouple_fault_filter_unit #(
  parameter int WINDOW = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  // input channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           read_ok,
  input  logic [tff_pkg::TEMP_W-1:0]     sample_temp,
  // output channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [tff_pkg::STATUS_W-1:0]   status,
  output logic [tff_pkg::FILT_W-1:0]     filtered_temp,
  output logic                           error_state,
  output logic [tff_pkg::CNT_W-1:0]      error_count,
  // register port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [2:0]                     paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  localparam int CW    = $clog2(WINDOW + 1);
  localparam int CMP_W = (CW > tff_pkg::CNT_W) ? CW : tff_pkg::CNT_W;

  logic [tff_pkg::CNT_W-1:0]  max_errors;
  logic [tff_pkg::TEMP_W-1:0] max_safe_temp;

  logic [CW-1:0]              fill_count;
  logic [CW-1:0]              window_errors;
  logic [tff_pkg::FILT_W-1:0] smoothed_temp;
  tff_pkg::result_t           result;

  logic [CW-1:0]              fill_count_next;
  logic [CW-1:0]              window_errors_next;
  logic [tff_pkg::FILT_W-1:0] smoothed_temp_next;
  tff_pkg::result_t           result_next;

  logic                       accept;
  logic                       fail;
  logic                       bad;
  logic                       update;
  logic                       full;
  logic                       oldest;
  logic [tff_pkg::FILT_W-1:0] ema_temp;
  logic [CMP_W-1:0]           cnt_ext;
  logic [WINDOW:0]            chain;

  // config port
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_errors    <= tff_pkg::MAX_ERRORS_RST;
      max_safe_temp <= tff_pkg::MAX_SAFE_TEMP_RST;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        tff_pkg::REG_MAX_ERRORS:    max_errors    <= pwdata[tff_pkg::CNT_W-1:0];
        tff_pkg::REG_MAX_SAFE_TEMP: max_safe_temp <= pwdata[tff_pkg::TEMP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      tff_pkg::REG_MAX_ERRORS:    prdata = {{(32-tff_pkg::CNT_W){1'b0}}, max_errors};
      tff_pkg::REG_MAX_SAFE_TEMP: prdata = {{(32-tff_pkg::TEMP_W){1'b0}}, max_safe_temp};
      default:                    prdata = '0;
    endcase
  end

  // handshake
  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  // window of error bits, newest at the head of the chain
  assign chain[0] = bad;

  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    tff_cell u_cell (
      .clk     (clk),
      .shift   (update),
      .bit_in  (chain[i]),
      .bit_out (chain[i+1])
    );
  end

  assign oldest = chain[WINDOW];

  tff_ema u_ema (
    .old_temp (smoothed_temp),
    .sample   (sample_temp),
    .new_temp (ema_temp)
  );

  always_comb begin
    fail = (CMP_W'(window_errors) >= CMP_W'(max_errors))
        || (smoothed_temp > {max_safe_temp, {tff_pkg::FRAC_W{1'b0}}});
    bad    = !read_ok || (sample_temp == '0);
    update = accept && !fail;
    full   = (fill_count == CW'(WINDOW));

    fill_count_next    = fill_count;
    window_errors_next = window_errors;
    smoothed_temp_next = smoothed_temp;
    if (update) begin
      if (!full) begin
        fill_count_next = fill_count + CW'(1);
      end
      window_errors_next = window_errors - CW'(full && oldest) + CW'(bad);
      if (!bad) begin
        smoothed_temp_next = ema_temp;
      end
    end

    if (fail) begin
      result_next.status = tff_pkg::ST_FAILURE;
    end else if (bad) begin
      result_next.status = tff_pkg::ST_IGNORED;
    end else begin
      result_next.status = tff_pkg::ST_UPDATED;
    end
    result_next.filtered_temp = smoothed_temp_next;
    result_next.error_state   = (smoothed_temp_next == '0)
                             || (CMP_W'(window_errors_next) >= CMP_W'(max_errors));
    cnt_ext = CMP_W'(window_errors_next);
    if (cnt_ext > CMP_W'(tff_pkg::CNT_SAT)) begin
      result_next.error_count = tff_pkg::CNT_SAT;
    end else begin
      result_next.error_count = cnt_ext[tff_pkg::CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count    <= '0;
      window_errors <= '0;
      smoothed_temp <= '0;
      out_valid     <= 1'b0;
    end else begin
      fill_count    <= fill_count_next;
      window_errors <= window_errors_next;
      smoothed_temp <= smoothed_temp_next;
      if (accept) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result <= result_next;
    end
  end

  assign status        = result.status;
  assign filtered_temp = result.filtered_temp;
  assign error_state   = result.error_state;
  assign error_count   = result.error_count;

  // checks
  a_count_le_fill: assert property (@(posedge clk) disable iff (rst)
    window_errors <= fill_count)
    else $error("window error count exceeds fill count");

  a_fail_holds_state: assert property (@(posedge clk) disable iff (rst)
    accept && fail |=> $stable(smoothed_temp) && $stable(window_errors) && $stable(fill_count))
    else $error("state changed on a failure beat");

  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted beat produced no result");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == tff_pkg::ST_UPDATED || status == tff_pkg::ST_IGNORED
                   || status == tff_pkg::ST_FAILURE))
    else $error("undefined status code");

endmodule
